FILE: sv/threshold_run_peak_detector_defines.svh
// Assertion macros shared by the threshold run peak detector RTL.
// Has no dependencies. Define NO_ASSERTIONS to compile the checks out.
`ifndef THRESHOLD_RUN_PEAK_DETECTOR_DEFINES_SVH
`define THRESHOLD_RUN_PEAK_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define TRPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("threshold_run_peak_detector: assertion failed");

// Condition must never be true outside reset.
`define TRPD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("threshold_run_peak_detector: forbidden condition seen");

`else

`define TRPD_ASSERT(lbl, clk, rst_n, prop)
`define TRPD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: sv/trpd_pkg.sv
// Shared types and constants of the threshold run peak detector.
// No dependencies; imported by every module of the block.
package trpd_pkg;

  // Field widths.
  localparam int INDEX_BITS  = 20;
  localparam int SAMPLE_BITS = 16;

  // Stream data widths, rounded up to whole bytes.
  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int RESULT_BITS    = 2 * INDEX_BITS + SAMPLE_BITS;
  localparam int OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

  // Reset value of the threshold: 5.0 in Q8.8.
  localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(1280);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [INDEX_BITS-1:0]         index_t;

  // One reported run.
  typedef struct packed {
    sample_t peak_value;
    index_t  fall_index;
    index_t  rise_index;
  } result_t;

endpackage

FILE: sv/trpd_core.sv
// Run tracking for the threshold run peak detector: compare, peak update, indices.
// Depends on trpd_pkg and the assertion macros header.
`include "threshold_run_peak_detector_defines.svh"

module trpd_core
  import trpd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  sample_t sample_value_i,
  input  logic    window_last_i,
  input  sample_t threshold_i,
  output logic    result_valid_o,
  output result_t result_o
);

  index_t  sample_index_q, sample_index_d;
  sample_t prev_sample_q, prev_sample_d;
  logic    prev_above_q, prev_above_d;
  logic    have_prev_q, have_prev_d;
  logic    run_open_q, run_open_d;
  index_t  run_start_q, run_start_d;
  sample_t run_peak_q, run_peak_d;

  logic   above;
  index_t prev_index;

  assign above      = (sample_value_i >= threshold_i);
  assign prev_index = sample_index_q - index_t'(1);

  // A run closes on the first below sample; report it if its peak qualifies.
  assign result_valid_o = accept_i && have_prev_q && prev_above_q && !above &&
                          run_open_q && (run_peak_q >= threshold_i);
  assign result_o.rise_index = run_start_q;
  assign result_o.fall_index = prev_index;
  assign result_o.peak_value = run_peak_q;

  // Next-state logic for one accepted sample.
  always_comb begin
    sample_index_d = sample_index_q;
    prev_sample_d  = prev_sample_q;
    prev_above_d   = prev_above_q;
    have_prev_d    = have_prev_q;
    run_open_d     = run_open_q;
    run_start_d    = run_start_q;
    run_peak_d     = run_peak_q;
    if (accept_i) begin
      if (have_prev_q) begin
        if (!prev_above_q && above) begin
          run_open_d  = 1'b1;
          run_start_d = prev_index;
          run_peak_d  = prev_sample_q;
        end else if (prev_above_q && above) begin
          if (run_open_q && (prev_sample_q > run_peak_q)) begin
            run_peak_d = prev_sample_q;
          end
        end else if (prev_above_q && !above) begin
          run_open_d = 1'b0;
        end
      end else begin
        run_open_d = 1'b0;
      end
      prev_sample_d  = sample_value_i;
      prev_above_d   = above;
      have_prev_d    = 1'b1;
      sample_index_d = sample_index_q + index_t'(1);
      // Window end clears the position and any open run.
      if (window_last_i) begin
        sample_index_d = '0;
        have_prev_d    = 1'b0;
        run_open_d     = 1'b0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q <= '0;
      prev_sample_q  <= '0;
      prev_above_q   <= 1'b0;
      have_prev_q    <= 1'b0;
      run_open_q     <= 1'b0;
      run_start_q    <= '0;
      run_peak_q     <= '0;
    end else begin
      sample_index_q <= sample_index_d;
      prev_sample_q  <= prev_sample_d;
      prev_above_q   <= prev_above_d;
      have_prev_q    <= have_prev_d;
      run_open_q     <= run_open_d;
      run_start_q    <= run_start_d;
      run_peak_q     <= run_peak_d;
    end
  end

  `TRPD_ASSERT(a_run_needs_prev, clk_i, rst_ni, run_open_q |-> have_prev_q)
  `TRPD_ASSERT(a_last_clears, clk_i, rst_ni,
               (accept_i && window_last_i) |=> (!have_prev_q && !run_open_q &&
                                                sample_index_q == '0))
  `TRPD_ASSERT_NEVER(a_result_without_run, clk_i, rst_ni,
                     result_valid_o && !(run_open_q && prev_above_q))

endmodule

FILE: sv/trpd_skid.sv
// Two-entry output stage: a result register plus a skid register.
// Depends on trpd_pkg and the assertion macros header.
`include "threshold_run_peak_detector_defines.svh"

module trpd_skid
  import trpd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  result_t in_data_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output result_t out_data_o,
  input  logic    out_ready_i
);

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop         = main_valid_q && out_ready_i;
  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // Control: the skid entry fills only when the main entry is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (pop && skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (pop || !main_valid_q) begin
        main_valid_q <= in_valid_i;
      end else if (in_valid_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    priority if (pop && skid_valid_q) begin
      main_q <= skid_q;
    end else if (pop || !main_valid_q) begin
      main_q <= in_data_i;
    end else if (in_valid_i) begin
      skid_q <= in_data_i;
    end
  end

  `TRPD_ASSERT(a_skid_implies_main, clk_i, rst_ni, skid_valid_q |-> main_valid_q)
  `TRPD_ASSERT_NEVER(a_push_into_full, clk_i, rst_ni, in_valid_i && skid_valid_q)
  `TRPD_ASSERT(a_skid_drains_to_main, clk_i, rst_ni,
               (pop && skid_valid_q) |=> (main_valid_q && !skid_valid_q))

endmodule

FILE: sv/threshold_run_peak_detector.sv
// Threshold run peak detector: takes one sample item per clock cycle while the
// output stage has room. A reported run is registered into the output stage
// when the item that closes it is accepted. A two-entry output stage holds
// results while the master side stalls; the slave side keeps taking items until
// both entries are full, so the only limit on rate is the output backpressure.
// The threshold is written through its own channel, which is always ready.
// Depends on trpd_pkg, trpd_core, trpd_skid.
module threshold_run_peak_detector
  import trpd_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Threshold write channel: level_threshold, signed Q8.8.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [SAMPLE_BITS-1:0]    cfg_data_i,
  // Sample stream.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,  // sample_value
  input  logic                      s_axis_tlast,  // window_last
  // Result stream.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata   // rise_index, fall_index, peak_value
);

  sample_t threshold_q;
  logic    accept;
  logic    result_valid;
  result_t result;
  result_t out_result;

  // Threshold register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      threshold_q <= cfg_data_i;
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  trpd_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .sample_value_i (sample_t'(s_axis_tdata[SAMPLE_BITS-1:0])),
    .window_last_i  (s_axis_tlast),
    .threshold_i    (threshold_q),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  trpd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (result_valid),
    .in_data_i   (result),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_result),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = OUT_TDATA_BITS'(out_result);

endmodule
